[rtl/core/assert_macros.svh]
// assertion macros for the core rtl
// no dependencies; checks compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked while out of reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked while out of reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_IMPL(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/sitda_pkg.sv]
// package for the signed integer to decimal ascii core
// constants, stage record type and the double dabble step; no dependencies
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_W        = 4;
  localparam int NUM_DIGITS     = 10;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int CONV_STAGES    = 8;
  localparam int BITS_PER_STAGE = VALUE_W / CONV_STAGES;
  localparam int POS_W          = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               neg;
  } conv_st_t;

  // one shift-add-3 step: correct each digit, then shift the next bit in
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bit_in);
    logic [BCD_W-1:0]   acc;
    logic [DIGIT_W-1:0] nib;
    acc = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nib = acc[i*DIGIT_W +: DIGIT_W];
      if (nib >= 4'd5) begin
        acc[i*DIGIT_W +: DIGIT_W] = nib + 4'd3;
      end
    end
    return {acc[BCD_W-2:0], bit_in};
  endfunction

endpackage

[rtl/core/signed_int_to_decimal_ascii_core.sv]
// signed 32-bit integer to decimal ascii text, one character per output beat
// depends on sitda_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   in channel: in_valid / in_stall / in_value (signed 32 bit). A beat is
//   taken when in_valid is high and in_stall is low.
//   out channel: out_valid / out_stall / out_character / out_last_char.
//   Each number leaves as 1 to 11 characters, most significant first: an
//   optional '-', then the digits with no leading zeros. out_last_char marks
//   the final character of a number.
//   A number passes the input stage, eight double dabble stages of four bits
//   each, a digit count stage, the character buffer and the output register.
//   Characters leave at one per cycle while out_stall is low; a number holds
//   the character buffer until its last character is emitted, and the next
//   number can load as that character is emitted, so back-to-back numbers
//   leave without gaps. The conversion pipeline accepts a new number every cycle
//   while the buffer keeps up; it advances as one unit and holds whenever its
//   count stage is full and the buffer is busy and not emitting a last digit.
//   Reset (rst_n low, synchronous) drops every number in flight.
//   While out_stall is high the output beat holds; the buffer and pipeline
//   back up and in_stall rises once the count stage is occupied.
module signed_int_to_decimal_ascii_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]      out_character,
  output logic                              out_last_char
);

  // conversion pipeline
  logic [sitda_pkg::CONV_STAGES:0] vld_r;
  sitda_pkg::conv_st_t             st_r   [sitda_pkg::CONV_STAGES+1];
  sitda_pkg::conv_st_t             st_nxt [sitda_pkg::CONV_STAGES+1];
  sitda_pkg::conv_st_t             work;
  logic [sitda_pkg::VALUE_W-1:0]   raw;

  // digit count stage
  logic                            cnt_vld_r;
  logic [sitda_pkg::BCD_W-1:0]     cnt_bcd_r;
  logic                            cnt_neg_r;
  logic [sitda_pkg::POS_W-1:0]     cnt_top_r;
  logic [sitda_pkg::POS_W-1:0]     cnt_top_nxt;

  // character buffer
  logic                            busy_r, busy_nxt;
  logic                            sign_pend_r, sign_pend_nxt;
  logic [sitda_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [sitda_pkg::BCD_W-1:0]     buf_bcd_r;
  logic [sitda_pkg::DIGIT_W-1:0]   dig;

  // output register
  logic                            out_valid_r, out_valid_nxt;
  logic [sitda_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                            out_last_r, out_last_nxt;

  logic out_ready, emit, emit_last, load, adv;

  assign raw = $unsigned(in_value);

  always_comb begin
    st_nxt[0].bcd = '0;
    st_nxt[0].neg = raw[sitda_pkg::VALUE_W-1];
    st_nxt[0].bin = raw[sitda_pkg::VALUE_W-1] ? (~raw + 32'd1) : raw;
    work = st_r[0];
    for (int k = 0; k < sitda_pkg::CONV_STAGES; k++) begin
      work = st_r[k];
      for (int b = 0; b < sitda_pkg::BITS_PER_STAGE; b++) begin
        work.bcd = sitda_pkg::dd_step(work.bcd, work.bin[sitda_pkg::VALUE_W-1]);
        work.bin = {work.bin[sitda_pkg::VALUE_W-2:0], 1'b0};
      end
      st_nxt[k+1] = work;
    end
  end

  // index of the most significant nonzero digit, zero for the value zero
  always_comb begin
    cnt_top_nxt = '0;
    for (int i = 1; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (st_r[sitda_pkg::CONV_STAGES].bcd[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W]
          != '0) begin
        cnt_top_nxt = sitda_pkg::POS_W'(i);
      end
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_ready;
  assign emit_last = emit && !sign_pend_r && (pos_r == '0);
  assign load      = cnt_vld_r && (!busy_r || emit_last);
  assign adv       = !cnt_vld_r || load;
  assign in_stall  = !adv;

  assign dig = buf_bcd_r[{pos_r, 2'b00} +: sitda_pkg::DIGIT_W];

  always_comb begin
    busy_nxt      = busy_r;
    sign_pend_nxt = sign_pend_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_ready) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      if (sign_pend_r) begin
        out_char_nxt  = sitda_pkg::ASCII_MINUS;
        out_last_nxt  = 1'b0;
        sign_pend_nxt = 1'b0;
      end else begin
        out_char_nxt = sitda_pkg::ASCII_ZERO + {4'd0, dig};
        out_last_nxt = (pos_r == '0);
        if (pos_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          pos_nxt = pos_r - 4'd1;
        end
      end
    end
    if (load) begin
      busy_nxt      = 1'b1;
      sign_pend_nxt = cnt_neg_r;
      pos_nxt       = cnt_top_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cnt_vld_r   <= 1'b0;
      busy_r      <= 1'b0;
      sign_pend_r <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r     <= {vld_r[sitda_pkg::CONV_STAGES-1:0], in_valid};
        cnt_vld_r <= vld_r[sitda_pkg::CONV_STAGES];
      end
      busy_r      <= busy_nxt;
      sign_pend_r <= sign_pend_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= sitda_pkg::CONV_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
      cnt_bcd_r <= st_r[sitda_pkg::CONV_STAGES].bcd;
      cnt_neg_r <= st_r[sitda_pkg::CONV_STAGES].neg;
      cnt_top_r <= cnt_top_nxt;
    end
    if (load) begin
      buf_bcd_r <= cnt_bcd_r;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

  // a minus sign never ends a number
  `AST_IMPL(a_minus_not_last, clk, rst_n,
    out_valid_r && (out_char_r == sitda_pkg::ASCII_MINUS), !out_last_r)
  // digit pointer stays inside the ten digit buffer
  `AST_IMPL(a_pos_in_range, clk, rst_n, busy_r, pos_r < 4'd10)
  // pipeline only holds when the buffer is busy and the count stage full
  `AST_IMPL(a_hold_cause, clk, rst_n, in_stall, cnt_vld_r && busy_r)
  // an emitted last digit frees the buffer unless a new number loads
  `AST_NEXT(a_free_after_last, clk, rst_n, emit_last && !load, !busy_r)

endmodule
